FILE: hdl/pbs_pkg.sv
// ----------------------------------------------------------------------------
// Pixel bitplane splitter package
// Shared constants and the group record passed from the front to the back.
// ----------------------------------------------------------------------------
`default_nettype none

package pbs_pkg;

   localparam int MAX_PLANES   = 8;
   localparam int PLANE_IDX_W  = $clog2(MAX_PLANES);
   localparam int PLANE_CNT_W  = $clog2(MAX_PLANES + 1);
   localparam int GROUP_SIZE   = 8;
   localparam int GROUP_CNT_W  = $clog2(GROUP_SIZE);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] BPP_RESET = 4'd4;

   // One finished group: a byte for every plane plus the plane count and the frame-end flag.
   typedef struct packed {
      logic [MAX_PLANES-1:0][GROUP_SIZE-1:0] plane_bytes;
      logic [PLANE_CNT_W-1:0]                planes;
      logic                                  frame_end;
   } group_type;

endpackage

`default_nettype wire

FILE: hdl/pbs_front.sv
// ----------------------------------------------------------------------------
// Pixel bitplane splitter front end
// Holds the depth register, shifts pixel bits into the plane registers and
// pushes a finished group into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pbs_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [3:0]          csr_wr_data,
   input  wire logic                accept,
   input  wire logic [7:0]          pixel_value,
   input  wire logic                frame_last,
   output logic                     push,
   output pbs_pkg::group_type       push_group
);
   import pbs_pkg::*;

   logic [3:0]                            bpp_ff, bpp_in;
   logic [MAX_PLANES-1:0][GROUP_SIZE-1:0] shift_ff, shift_in;
   logic [MAX_PLANES-1:0][GROUP_SIZE-1:0] shifted;
   logic [GROUP_CNT_W-1:0]                count_ff, count_in;
   logic [PLANE_CNT_W-1:0]                planes;
   logic                                  complete;

   // A depth of zero still uses one plane; anything above the maximum is capped.
   always_comb begin
      if (bpp_ff == 4'd0) begin
         planes = PLANE_CNT_W'(1);
      end else if (32'(bpp_ff) > MAX_PLANES) begin
         planes = PLANE_CNT_W'(MAX_PLANES);
      end else begin
         planes = PLANE_CNT_W'(bpp_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_PLANES; i++) begin
         if (PLANE_CNT_W'(i) < planes) begin
            shifted[i] = {shift_ff[i][GROUP_SIZE-2:0], pixel_value[i]};
         end else begin
            shifted[i] = shift_ff[i];
         end
      end
   end

   assign complete = (count_ff == GROUP_CNT_W'(GROUP_SIZE - 1)) || frame_last;

   always_comb begin
      bpp_in   = csr_wr_en ? csr_wr_data : bpp_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      if (accept) begin
         if (complete) begin
            shift_in = '0;
            count_in = '0;
         end else begin
            shift_in = shifted;
            count_in = count_ff + GROUP_CNT_W'(1);
         end
      end
   end

   assign push                   = accept && complete;
   assign push_group.plane_bytes = shifted;
   assign push_group.planes      = planes;
   assign push_group.frame_end   = frame_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= BPP_RESET;
         shift_ff <= '0;
         count_ff <= '0;
      end else begin
         bpp_ff   <= bpp_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/pbs_queue.sv
// ----------------------------------------------------------------------------
// Pixel bitplane splitter group queue
// Short first-in first-out buffer of finished groups between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module pbs_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire pbs_pkg::group_type  push_group,
   input  wire logic                pop,
   output logic                     full,
   output logic                     head_valid,
   output pbs_pkg::group_type       head_group
);
   import pbs_pkg::*;

   group_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] fill_ff, fill_in;
   logic                   do_push, do_pop;

   assign full       = (fill_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_group = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/pbs_back.sv
// ----------------------------------------------------------------------------
// Pixel bitplane splitter back end
// Walks the planes of the head group, one plane word per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbs_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire pbs_pkg::group_type  head_group,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [2:0]               rsp_plane_number,
   output logic [7:0]               rsp_plane_byte,
   output logic                     rsp_group_last,
   output logic                     rsp_frame_end
);
   import pbs_pkg::*;

   logic [PLANE_IDX_W-1:0] idx_ff, idx_in;
   logic                   valid_ff, valid_in;
   logic [2:0]             number_ff, number_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   last_ff, last_in;
   logic                   end_ff, end_in;
   logic                   load;
   logic                   is_last;

   assign load    = head_valid && (!valid_ff || !rsp_stall);
   assign is_last = ({1'b0, idx_ff} + PLANE_CNT_W'(1)) == head_group.planes;
   assign pop     = load && is_last;

   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff && rsp_stall;
      number_in = number_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      end_in    = end_ff;
      if (load) begin
         idx_in    = is_last ? '0 : idx_ff + PLANE_IDX_W'(1);
         valid_in  = 1'b1;
         number_in = 3'(idx_ff);
         byte_in   = head_group.plane_bytes[idx_ff];
         last_in   = is_last;
         end_in    = head_group.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      number_ff <= number_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      end_ff    <= end_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_plane_number = number_ff;
   assign rsp_plane_byte   = byte_ff;
   assign rsp_group_last   = last_ff;
   assign rsp_frame_end    = end_ff;

endmodule

`default_nettype wire

FILE: hdl/pixel_bitplane_splitter_core.sv
// ----------------------------------------------------------------------------
// Pixel bitplane splitter core
// Chunky-to-planar conversion: pixels in, one byte per active bit plane out.
// ----------------------------------------------------------------------------
// The block takes one pixel word per cycle and never stalls it unless the
// two-group queue between the front end and the back end is full. Every
// eight pixels, or at a pixel flagged frame_last, the group is queued and the
// back end sends one plane word per cycle while rsp_stall is low, plane 0
// first, one word for each active plane. Output bandwidth therefore sets
// the sustained rate: up to eight plane words per eight pixels keeps one
// pixel per cycle, while frequent frame_last flushes at full depth cost eight
// words per pixel. The depth register must only be written while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_bitplane_splitter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_pixel_value,
   input  wire logic        req_frame_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_plane_number,
   output logic [7:0]       rsp_plane_byte,
   output logic             rsp_group_last,
   output logic             rsp_frame_end
);
   import pbs_pkg::*;

   logic      accept;
   logic      push;
   group_type push_group;
   logic      pop;
   logic      full;
   logic      head_valid;
   group_type head_group;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   pbs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .pixel_value (req_pixel_value),
      .frame_last  (req_frame_last),
      .push        (push),
      .push_group  (push_group)
   );

   pbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_group (head_group)
   );

   pbs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_group       (head_group),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_plane_number (rsp_plane_number),
      .rsp_plane_byte   (rsp_plane_byte),
      .rsp_group_last   (rsp_group_last),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule

`default_nettype wire

FILE: bench/tb_pixel_bitplane_splitter_core.sv
// ----------------------------------------------------------------------------
// Pixel bitplane splitter core testbench
// Streams pixel words through the core under several depth settings and idle
// patterns, predicts every plane word and compares each one as it leaves.
// ----------------------------------------------------------------------------
module tb_pixel_bitplane_splitter_core;
   timeunit 1ns;
   timeprecision 1ps;
   import pbs_pkg::*;

   typedef struct {
      logic [2:0] plane;
      logic [7:0] data;
      logic       group_last;
      logic       frame_end;
   } plane_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [3:0] csr_wr_data = 4'd0;
   logic       req_valid = 1'b0;
   logic [7:0] req_pixel_value = 8'd0;
   logic       req_frame_last = 1'b0;
   logic       rsp_stall = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [2:0] rsp_plane_number;
   logic [7:0] rsp_plane_byte;
   logic       rsp_group_last;
   logic       rsp_frame_end;

   // Predictor state.
   logic [3:0]     depth_reg = BPP_RESET;
   logic [7:0]     plane_bits [MAX_PLANES] = '{default: 8'h00};
   logic [3:0]     pixels_in_group = 4'd0;
   plane_word_type plane_words_due [$];

   int mismatches = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left = 0;

   pixel_bitplane_splitter_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_value  (req_pixel_value),
      .req_frame_last   (req_frame_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_plane_number (rsp_plane_number),
      .rsp_plane_byte   (rsp_plane_byte),
      .rsp_group_last   (rsp_group_last),
      .rsp_frame_end    (rsp_frame_end)
   );

   always #5 clock = ~clock;

   function automatic int planes_in_use(logic [3:0] depth);
      if (depth == 4'd0) return 1;
      if (depth > MAX_PLANES) return MAX_PLANES;
      return int'(depth);
   endfunction

   function automatic void predict_planes(logic [7:0] pix, logic last);
      int             planes;
      int             i;
      plane_word_type w;
      planes = planes_in_use(depth_reg);
      for (i = 0; i < planes; i++) plane_bits[i] = {plane_bits[i][6:0], pix[i]};
      pixels_in_group = pixels_in_group + 4'd1;
      if (pixels_in_group >= GROUP_SIZE || last) begin
         for (i = 0; i < planes; i++) begin
            w.plane      = 3'(i);
            w.data       = plane_bits[i];
            w.group_last = (i == planes - 1);
            w.frame_end  = last;
            plane_words_due = {plane_words_due, w};
         end
         for (i = 0; i < MAX_PLANES; i++) plane_bits[i] = 8'h00;
         pixels_in_group = 4'd0;
      end
   endfunction

   function automatic void check_field(string name, logic [7:0] expected, logic [7:0] actual);
      if (actual !== expected) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
         mismatches++;
      end
   endfunction

   // Receiver: a long hold-off takes priority over the random stall pattern.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      plane_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (plane_words_due.size() == 0) begin
            $display("%0t ns: unexpected plane word, expected nothing, actual plane %0d byte %0h",
                     $time, rsp_plane_number, rsp_plane_byte);
            mismatches++;
         end else begin
            w = plane_words_due.pop_front();
            check_field("plane_number", 8'(w.plane), 8'(rsp_plane_number));
            check_field("plane_byte", w.data, rsp_plane_byte);
            check_field("group_last", 8'(w.group_last), 8'(rsp_group_last));
            check_field("frame_end", 8'(w.frame_end), 8'(rsp_frame_end));
         end
      end
   end

   // Valid stays high after acceptance until the next falling edge, where the
   // next word or an idle cycle replaces it.
   task automatic send_pixel(input logic [7:0] pix, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_pixel_value <= pix;
      req_frame_last  <= last;
      do @(posedge clock); while (req_stall);
      predict_planes(pix, last);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (plane_words_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_depth(input logic [3:0] depth);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= depth;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      depth_reg = depth;
   endtask

   // Reset depth, a partial group, and pixel bits above the depth.
   task automatic test_default_depth();
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hF5, 1'b0);
      send_pixel(8'h0A, 1'b0);
      send_pixel(8'h3C, 1'b1);
      wait_drained();
   endtask

   task automatic test_depth_extremes();
      logic [7:0] pattern [8] = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hFF, 8'h7F};
      int         k;
      write_depth(4'd1);
      send_pixel(8'hFE, 1'b0);
      send_pixel(8'h01, 1'b0);
      send_pixel(8'hFF, 1'b1);
      // A full group whose eighth pixel also ends the frame.
      write_depth(4'd8);
      for (k = 0; k < 8; k++) send_pixel(pattern[k], k == 7);
      send_pixel(8'hA5, 1'b1);
      // Zero counts as one plane, anything above eight as eight.
      write_depth(4'd0);
      send_pixel(8'h03, 1'b0);
      send_pixel(8'h02, 1'b1);
      write_depth(4'd15);
      send_pixel(8'hC3, 1'b0);
      send_pixel(8'h81, 1'b1);
      wait_drained();
   endtask

   // The depth changes while a group is partly filled and nothing is pending.
   task automatic test_depth_mid_group();
      int k;
      write_depth(4'd8);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hFF, 1'b0);
      write_depth(4'd2);
      for (k = 0; k < 5; k++) send_pixel(8'($urandom), 1'b0);
      write_depth(4'd3);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h5A, 1'b0);
      write_depth(4'd8);
      send_pixel(8'hFF, 1'b1);
      wait_drained();
   endtask

   // The receiver holds off while short frames at full depth keep arriving,
   // so the group queue fills and the input stalls.
   task automatic test_backpressure();
      int k;
      write_depth(4'd8);
      hold_left = 150;
      for (k = 0; k < 40; k++) send_pixel(8'($urandom), k % 2 == 1);
      wait_drained();
      for (k = 0; k < 16; k++) send_pixel(8'($urandom), k == 15);
      wait_drained();
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct, input int items);
      int sent;
      int frame_len;
      int k;
      write_depth(4'($urandom_range(15)));
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(9) == 0) begin
            send_pixel(8'($urandom), 1'($urandom_range(1)));
            sent++;
         end else begin
            frame_len = $urandom_range(1, 20);
            for (k = 0; k < frame_len; k++) send_pixel(8'($urandom), k == frame_len - 1);
            sent += frame_len;
         end
      end
      wait_drained();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   task automatic test_random();
      run_random_phase(0, 0, 30);
      run_random_phase(76, 0, 30);
      run_random_phase(0, 76, 30);
      run_random_phase(13, 13, 30);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_depth();
      test_depth_extremes();
      test_depth_mid_group();
      test_backpressure();
      test_random();
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && plane_words_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
